### design/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants of the 3x3 median filter
// Payload structs of both channels, register indexes, command codes and
// the control word that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package mf3_pkg;

   // Payload of the input channel
   typedef struct packed {
      logic       command;
      logic [7:0] grey_value;
   } req_data_type;

   // Payload of the result channel
   typedef struct packed {
      logic [7:0] filtered_value;
      logic       frame_last;
   } rsp_data_type;

   // Command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // Register indexes (byte address bit 2)
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam int CSR_ADDR_BITS     = 3;
   localparam int CSR_DATA_BITS     = 32;
   localparam int WIDTH_FIELD_BITS  = 12;
   localparam int HEIGHT_FIELD_BITS = 13;
   localparam int ROW_BITS          = 12;
   localparam int WIDTH_MIN         = 3;
   localparam int WIDTH_RESET       = 640;
   localparam int HEIGHT_MIN        = 3;
   localparam int HEIGHT_MAX        = 4096;
   localparam int HEIGHT_RESET      = 480;

   // Queue between front and back
   localparam int FIFO_DEPTH      = 4;
   localparam int FIFO_LEVEL_BITS = $clog2(FIFO_DEPTH + 1);

   // Control word of one queued transaction
   typedef struct packed {
      logic pixel;     // shifts the window
      logic emit;      // produces a result
      logic interior;  // result is the window median
      logic last;      // last result of the frame
      logic sel_a;     // drain reads the newer row
   } item_ctl_type;

endpackage

### design/median_filter_3x3.sv
// ----------------------------------------------------------------------------
// median_filter_3x3: streaming 3x3 median filter on grey pixels
// Pixels enter in raster order; each leaves as the median of its 3x3
// neighbourhood, border pixels unchanged.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one transaction per pixel (command pixel) or drain tick.
//   rsp_*  : one transaction per result, frame_last on the frame's final one.
//   csr_*  : image_width at byte 0, image_height at byte 4; a write restarts
//            the frame; only write while the block is idle (not enforced).
// Timing
//   A pixel's result is produced by the transaction image_width+1 pixels
//   later (or by a drain tick at frame end). rsp_valid rises once that
//   transaction has passed the line store read stage, the queue, three
//   window/median stages and the result register.
//   Throughput is one transaction per cycle while req_stall stays low, set
//   by the single line store RAM port pair (one read, one write per cycle).
// Reset
//   Clears positions, pending count, queue and window; width 640, height
//   480. Line stores are not cleared; their stale entries only feed border
//   pixels, which pass through from the window center.
// Stall
//   rsp_stall freezes the back pipeline while a result waits; req is taken
//   until queue level plus the read stage reach four; then req_stall rises.
// ----------------------------------------------------------------------------
module median_filter_3x3
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                      csr_pready,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_data_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_data_type              rsp_data
);

   localparam int QW = $bits(item_ctl_type) + 3 * PIXEL_BITS;

   logic [FIFO_LEVEL_BITS-1:0] q_level;
   logic                       q_push, q_pop, q_valid;
   item_ctl_type               f_ctl, b_ctl;
   logic [PIXEL_BITS-1:0]      f_pix, f_a, f_b, b_pix, b_a, b_b;
   logic [QW-1:0]              q_out;

   mf3_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .q_level     (q_level),
      .q_push      (q_push),
      .q_ctl       (f_ctl),
      .q_pix       (f_pix),
      .q_a         (f_a),
      .q_b         (f_b)
   );

   mf3_fifo #(
      .DATA_BITS (QW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_ctl, f_pix, f_a, f_b}),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_out),
      .level     (q_level)
   );

   assign {b_ctl, b_pix, b_a, b_b} = q_out;

   mf3_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_ctl     (b_ctl),
      .q_pix     (b_pix),
      .q_a       (b_a),
      .q_b       (b_b),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### design/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mf3_ram #(
   parameter int DATA_BITS = 16,
   parameter int DEPTH     = 2048
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_BITS-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_BITS-1:0]         rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/mf3_front.sv
// ----------------------------------------------------------------------------
// mf3_front: register port, position tracking and line stores
// Accepts transactions, classifies them, reads and updates the two line
// stores and pushes one control word plus column data into the queue.
// ----------------------------------------------------------------------------
module mf3_front
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready,
   // input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  req_data_type                  req_data,
   // queue side
   input  logic [FIFO_LEVEL_BITS-1:0]    q_level,
   output logic                          q_push,
   output item_ctl_type                  q_ctl,
   output logic [PIXEL_BITS-1:0]         q_pix,
   output logic [PIXEL_BITS-1:0]         q_a,
   output logic [PIXEL_BITS-1:0]         q_b
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int PW = $clog2(MAX_WIDTH + 2);
   localparam int W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

   logic [WW-1:0]                width_ff, width_in;
   logic [HEIGHT_FIELD_BITS-1:0] height_ff, height_in;
   logic [CW-1:0]                in_col_ff, in_col_in;
   logic [ROW_BITS-1:0]          in_row_ff, in_row_in;
   logic [CW-1:0]                out_col_ff, out_col_in;
   logic [ROW_BITS-1:0]          out_row_ff, out_row_in;
   logic [PW-1:0]                pending_ff, pending_in;

   logic                         s1_valid_ff;
   item_ctl_type                 s1_ctl_ff;
   logic [PIXEL_BITS-1:0]        s1_pix_ff;
   logic [CW-1:0]                s1_addr_ff;
   logic                         fwd_ff;
   logic [2*PIXEL_BITS-1:0]      fwd_data_ff;

   logic                         cfg_write;
   logic [31:0]                  w32, h32, cfg_w, cfg_h;
   logic                         accept, is_pix, frame_start, tail_drop, drain_ok;
   logic [PW-1:0]                pend_eff;
   logic [CW-1:0]                outc;
   logic [ROW_BITS-1:0]          outr;
   logic                         emit_now;
   item_ctl_type                 ctl_new;
   logic [CW-1:0]                rd_addr;
   logic [2*PIXEL_BITS-1:0]      rd_q, s1_rd;
   logic                         wr_en;
   logic [2*PIXEL_BITS-1:0]      wr_data;

   // Register port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign w32        = 32'(width_ff);
   assign h32        = 32'(height_ff);

   always_comb begin
      cfg_w = 32'(csr_pwdata[WIDTH_FIELD_BITS-1:0]);
      if (cfg_w < WIDTH_MIN) begin
         cfg_w = WIDTH_MIN;
      end else if (cfg_w > MAX_WIDTH) begin
         cfg_w = MAX_WIDTH;
      end
      cfg_h = 32'(csr_pwdata[HEIGHT_FIELD_BITS-1:0]);
      if (cfg_h < HEIGHT_MIN) begin
         cfg_h = HEIGHT_MIN;
      end else if (cfg_h > HEIGHT_MAX) begin
         cfg_h = HEIGHT_MAX;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Classify the incoming transaction
   assign req_stall   = (32'(q_level) + 32'(s1_valid_ff)) >= FIFO_DEPTH;
   assign accept      = req_valid && !req_stall;
   assign is_pix      = (req_data.command == CMD_PIXEL);
   assign frame_start = (in_col_ff == '0) && (in_row_ff == '0);
   assign tail_drop   = is_pix && frame_start && (pending_ff != '0);
   assign drain_ok    = !is_pix && frame_start && (pending_ff != '0);
   assign pend_eff    = tail_drop ? '0 : pending_ff;
   assign outc        = tail_drop ? '0 : out_col_ff;
   assign outr        = tail_drop ? '0 : out_row_ff;
   assign emit_now    = is_pix ? (32'(pend_eff) >= w32 + 32'd1) : drain_ok;

   always_comb begin
      ctl_new.pixel    = is_pix;
      ctl_new.emit     = emit_now;
      ctl_new.interior = (outr != '0) && (32'(outr) + 32'd2 <= h32) &&
                         (outc != '0) && (32'(outc) + 32'd2 <= w32);
      ctl_new.sel_a    = (32'(outr) == h32 - 32'd1);
      ctl_new.last     = ctl_new.sel_a && (32'(outc) == w32 - 32'd1);
   end

   assign rd_addr = is_pix ? in_col_ff : outc;

   // Advance positions and pending count
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pending_in = pending_ff;
      if (cfg_write) begin
         if (csr_paddr[2] == REG_IMAGE_WIDTH) begin
            width_in = WW'(cfg_w);
         end else begin
            height_in = HEIGHT_FIELD_BITS'(cfg_h);
         end
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         pending_in = '0;
      end else if (accept && (is_pix || drain_ok)) begin
         out_col_in = outc;
         out_row_in = outr;
         if (is_pix) begin
            if (32'(in_col_ff) + 32'd1 >= w32) begin
               in_col_in = '0;
               if (32'(in_row_ff) + 32'd1 >= h32) begin
                  in_row_in = '0;
               end else begin
                  in_row_in = in_row_ff + 1'b1;
               end
            end else begin
               in_col_in = in_col_ff + 1'b1;
            end
            pending_in = emit_now ? pend_eff : pend_eff + 1'b1;
         end else begin
            pending_in = pending_ff - 1'b1;
         end
         if (emit_now) begin
            if (32'(outc) + 32'd1 >= w32) begin
               out_col_in = '0;
               if (32'(outr) + 32'd1 >= h32) begin
                  out_row_in = '0;
               end else begin
                  out_row_in = outr + 1'b1;
               end
            end else begin
               out_col_in = outc + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WW'(W_RESET);
         height_ff   <= HEIGHT_FIELD_BITS'(HEIGHT_RESET);
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         pending_ff  <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         pending_ff  <= pending_in;
         s1_valid_ff <= accept && (is_pix || drain_ok);
         fwd_ff      <= wr_en && (s1_addr_ff == rd_addr);
      end
   end

   // Hold the transaction while the line store read completes
   always_ff @(posedge clock) begin
      s1_ctl_ff   <= ctl_new;
      s1_pix_ff   <= PIXEL_BITS'(req_data.grey_value);
      s1_addr_ff  <= rd_addr;
      fwd_data_ff <= wr_data;
   end

   // Line stores: entry holds {newer row, older row}
   mf3_ram #(
      .DATA_BITS (2 * PIXEL_BITS),
      .DEPTH     (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_q)
   );

   // Forward a write that lands on the address just read
   assign s1_rd   = fwd_ff ? fwd_data_ff : rd_q;
   assign wr_en   = s1_valid_ff && s1_ctl_ff.pixel;
   assign wr_data = {s1_pix_ff, s1_rd[2*PIXEL_BITS-1:PIXEL_BITS]};

   assign q_push = s1_valid_ff;
   assign q_ctl  = s1_ctl_ff;
   assign q_pix  = s1_pix_ff;
   assign q_a    = s1_rd[2*PIXEL_BITS-1:PIXEL_BITS];
   assign q_b    = s1_rd[PIXEL_BITS-1:0];

   // Pending never exceeds one row plus one pixel
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pending_ff) <= w32 + 32'd1)
      else $error("pending count above row length plus one");

   // A drain only issues once the frame input is complete
   a_drain_at_frame_end: assert property (@(posedge clock) disable iff (reset)
      (accept && drain_ok) |-> (in_col_ff == '0 && in_row_ff == '0))
      else $error("drain issued in mid-frame");

endmodule

### design/mf3_fifo.sv
// ----------------------------------------------------------------------------
// mf3_fifo: short queue between front and back
// Register-based FIFO with a fill level for flow control upstream.
// ----------------------------------------------------------------------------
module mf3_fifo
   import mf3_pkg::*;
#(
   parameter int DATA_BITS = 29
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [DATA_BITS-1:0]        push_data,
   input  logic                        pop,
   output logic                        pop_valid,
   output logic [DATA_BITS-1:0]        pop_data,
   output logic [FIFO_LEVEL_BITS-1:0]  level
);

   localparam int AW = $clog2(FIFO_DEPTH);

   logic [DATA_BITS-1:0]       slot_ff [FIFO_DEPTH];
   logic [AW-1:0]              head_ff, head_in, tail_ff, tail_in;
   logic [FIFO_LEVEL_BITS-1:0] level_ff, level_in;
   logic                       do_pop;

   assign do_pop    = pop && (level_ff != '0);
   assign pop_valid = (level_ff != '0);
   assign pop_data  = slot_ff[head_ff];
   assign level     = level_ff;

   // Advance pointers and level
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      level_in = level_ff;
      if (push) begin
         tail_in = (32'(tail_ff) == FIFO_DEPTH - 1) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (32'(head_ff) == FIFO_DEPTH - 1) ? '0 : head_ff + 1'b1;
      end
      if (push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (!push && do_pop) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (32'(level_ff) < FIFO_DEPTH || do_pop))
      else $error("queue overflow");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      32'(level_ff) <= FIFO_DEPTH)
      else $error("queue level out of range");

endmodule

### design/mf3_back.sv
// ----------------------------------------------------------------------------
// mf3_back: 3x3 window and pipelined median
// Pops queued transactions, shifts the window, sorts columns, forms the
// median in three compare stages and holds the result register.
// ----------------------------------------------------------------------------
module mf3_back
   import mf3_pkg::*;
#(
   parameter int PIXEL_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // queue side
   input  logic                   q_valid,
   output logic                   q_pop,
   input  item_ctl_type           q_ctl,
   input  logic [PIXEL_BITS-1:0]  q_pix,
   input  logic [PIXEL_BITS-1:0]  q_a,
   input  logic [PIXEL_BITS-1:0]  q_b,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_data_type           rsp_data
);

   typedef logic [PIXEL_BITS-1:0] pix_type;

   function automatic pix_type min2(pix_type x, pix_type y);
      return (x < y) ? x : y;
   endfunction

   function automatic pix_type max2(pix_type x, pix_type y);
      return (x > y) ? x : y;
   endfunction

   function automatic pix_type med3(pix_type x, pix_type y, pix_type z);
      return max2(min2(x, y), min2(max2(x, y), z));
   endfunction

   pix_type      window_ff [9];
   logic         adv;
   logic         b0_valid_ff, b1_valid_ff, b2_valid_ff;
   item_ctl_type b0_ctl_ff, b1_ctl_ff, b2_ctl_ff;
   pix_type      b0_dval_ff, b1_plain_ff, b2_plain_ff;
   pix_type      b1_lo_ff [3];
   pix_type      b1_mid_ff [3];
   pix_type      b1_hi_ff [3];
   pix_type      b2_lo_ff, b2_mid_ff, b2_hi_ff;
   logic         rsp_valid_ff;
   pix_type      rsp_value_ff;
   logic         rsp_last_ff;
   logic [15:0]  value_ext;

   // Move the whole back pipeline when the result register frees up
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv && q_valid;

   // Shift the window on each pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= '0;
         end
      end else if (q_pop && q_ctl.pixel) begin
         for (int k = 0; k < 3; k++) begin
            window_ff[k*3]     <= window_ff[k*3 + 1];
            window_ff[k*3 + 1] <= window_ff[k*3 + 2];
         end
         window_ff[2] <= q_b;
         window_ff[5] <= q_a;
         window_ff[8] <= q_pix;
      end
   end

   // Stage valid bits and result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff  <= 1'b0;
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         b0_valid_ff  <= q_valid;
         b1_valid_ff  <= b0_valid_ff;
         b2_valid_ff  <= b1_valid_ff;
         rsp_valid_ff <= b2_valid_ff && b2_ctl_ff.emit;
      end
   end

   // Column sort, then max of lows, median of middles, min of highs
   always_ff @(posedge clock) begin
      if (adv) begin
         b0_ctl_ff  <= q_ctl;
         b0_dval_ff <= q_ctl.sel_a ? q_a : q_b;
         b1_ctl_ff  <= b0_ctl_ff;
         b1_plain_ff <= b0_ctl_ff.pixel ? window_ff[4] : b0_dval_ff;
         for (int c = 0; c < 3; c++) begin
            b1_lo_ff[c]  <= min2(min2(window_ff[c], window_ff[c+3]), window_ff[c+6]);
            b1_mid_ff[c] <= med3(window_ff[c], window_ff[c+3], window_ff[c+6]);
            b1_hi_ff[c]  <= max2(max2(window_ff[c], window_ff[c+3]), window_ff[c+6]);
         end
         b2_ctl_ff   <= b1_ctl_ff;
         b2_plain_ff <= b1_plain_ff;
         b2_lo_ff    <= max2(max2(b1_lo_ff[0], b1_lo_ff[1]), b1_lo_ff[2]);
         b2_mid_ff   <= med3(b1_mid_ff[0], b1_mid_ff[1], b1_mid_ff[2]);
         b2_hi_ff    <= min2(min2(b1_hi_ff[0], b1_hi_ff[1]), b1_hi_ff[2]);
         rsp_value_ff <= (b2_ctl_ff.pixel && b2_ctl_ff.interior) ?
                         med3(b2_lo_ff, b2_mid_ff, b2_hi_ff) : b2_plain_ff;
         rsp_last_ff  <= b2_ctl_ff.last;
      end
   end

   assign value_ext               = 16'(rsp_value_ff);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_data.filtered_value = value_ext[7:0];
   assign rsp_data.frame_last     = rsp_last_ff;

   // A stalled result stays put while the pipeline is frozen
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_value_ff)))
      else $error("result changed under stall");

endmodule

### tb/sv/median_filter_3x3_tb.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_tb: self-checking bench of the 3x3 median filter
// Streams whole frames of random grey pixels, drain ticks and noise through
// the block under random idling on both channels. A behavioral copy of the
// filter predicts every result; results are compared in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module median_filter_3x3_tb;
   import mf3_pkg::*;

   localparam int MAXW       = 2048;
   localparam int QUIET_MAX  = 20000;
   localparam int TAIL_WAIT  = 16;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   logic                     req_valid;
   logic                     req_stall;
   req_data_type             req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_data_type             rsp_data;

   median_filter_3x3 dut (.*);

   // Filter state mirror
   logic [7:0]  row_newer [MAXW];
   logic [7:0]  row_older [MAXW];
   logic [7:0]  win [9];
   int unsigned col_in, row_in, col_out, row_out, backlog;
   int unsigned img_w, img_h;

   rsp_data_type expected_pixels[$];
   int unsigned  error_count;
   int unsigned  result_count;
   int unsigned  quiet_cycles;
   bit           rsp_idle_on;
   bit           done;

   // Generate the clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   function automatic logic [7:0] window_median();
      logic [7:0] v [9];
      logic [7:0] t;
      int j;
      foreach (win[i]) v[i] = win[i];
      for (int i = 1; i < 9; i++) begin
         t = v[i];
         j = i - 1;
         while (j >= 0 && v[j] > t) begin
            v[j + 1] = v[j];
            j--;
         end
         v[j + 1] = t;
      end
      return v[4];
   endfunction

   function automatic void restart_frame();
      col_in = 0; row_in = 0; col_out = 0; row_out = 0; backlog = 0;
   endfunction

   function automatic void push_result(input logic [7:0] value);
      rsp_data_type r;
      r.filtered_value = value;
      r.frame_last = (row_out == img_h - 1 && col_out == img_w - 1);
      expected_pixels.push_back(r);
      col_out++;
      if (col_out >= img_w) begin
         col_out = 0;
         row_out++;
         if (row_out >= img_h) row_out = 0;
      end
   endfunction

   // Predict the result (if any) of one accepted transaction
   function automatic void predict_filter(input req_data_type item);
      int unsigned c;
      if (item.command == CMD_PIXEL) begin
         if (col_in == 0 && row_in == 0 && backlog > 0) begin
            backlog = 0; col_out = 0; row_out = 0;
         end
         c = col_in;
         for (int k = 0; k < 3; k++) begin
            win[k*3]     = win[k*3 + 1];
            win[k*3 + 1] = win[k*3 + 2];
         end
         win[2] = row_older[c];
         win[5] = row_newer[c];
         win[8] = item.grey_value;
         row_older[c] = row_newer[c];
         row_newer[c] = item.grey_value;
         col_in++;
         if (col_in >= img_w) begin
            col_in = 0;
            row_in++;
            if (row_in >= img_h) row_in = 0;
         end
         backlog++;
         if (backlog < img_w + 2) return;
         if (row_out >= 1 && row_out + 2 <= img_h && col_out >= 1 && col_out + 2 <= img_w)
            push_result(window_median());
         else
            push_result(win[4]);
         backlog--;
      end else begin
         if (backlog == 0 || col_in != 0 || row_in != 0) return;
         push_result(row_out == img_h - 1 ? row_newer[col_out] : row_older[col_out]);
         backlog--;
      end
   endfunction

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", rsp_data.filtered_value));
         end else begin
            if (rsp_data.filtered_value !== expected_pixels[0].filtered_value)
               report_mismatch($sformatf("filtered_value %0d, want %0d",
                  rsp_data.filtered_value, expected_pixels[0].filtered_value));
            if (rsp_data.frame_last !== expected_pixels[0].frame_last)
               report_mismatch($sformatf("frame_last %0b, want %0b",
                  rsp_data.frame_last, expected_pixels[0].frame_last));
            void'(expected_pixels.pop_front());
         end
      end
   end

   // Randomly stall the result side in bursts
   always @(posedge clock) begin
      if (reset || !rsp_idle_on) begin
         rsp_stall <= 1'b0;
      end else begin
         repeat ($urandom_range(1, 16)) @(posedge clock);
         rsp_stall <= ($urandom_range(0, 2) == 0);
      end
   end

   // Watchdog on acceptance activity
   always @(posedge clock) begin
      if (reset || done || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
         $display("timeout, %0d results still expected", expected_pixels.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Send one transaction, with an optional random gap before it
   task automatic send_item(input logic cmd, input logic [7:0] grey, input bit gaps);
      if (gaps && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{command: cmd, grey_value: grey};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_filter('{command: cmd, grey_value: grey});
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
   endtask

   // APB write, then restart the mirror
   task automatic write_reg(input logic idx, input logic [31:0] value);
      int unsigned v;
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (idx == REG_IMAGE_WIDTH) begin
         v = value[11:0];
         img_w = v < 3 ? 3 : (v > MAXW ? MAXW : v);
      end else begin
         v = value[12:0];
         img_h = v < 3 ? 3 : (v > 4096 ? 4096 : v);
      end
      restart_frame();
      @(posedge clock);
   endtask

   // One full frame with random content, then its drain ticks
   task automatic run_frame(input int unsigned pix_max, input bit gaps);
      for (int i = 0; i < img_w * img_h; i++)
         send_item(CMD_PIXEL, 8'($urandom_range(0, pix_max)), gaps);
      for (int i = 0; i < img_w + 1; i++) send_item(CMD_DRAIN, 8'($urandom), gaps);
   endtask

   typedef struct {
      logic       cmd;
      logic [7:0] grey;
   } stim_row_type;

   // Directed 3x3 frame: extremes, early drain, full drain, one stray drain
   stim_row_type directed_rows[14] = '{
      '{CMD_DRAIN, 8'hff}, '{CMD_PIXEL, 8'h00}, '{CMD_PIXEL, 8'hff}, '{CMD_DRAIN, 8'h00},
      '{CMD_PIXEL, 8'h80}, '{CMD_PIXEL, 8'h7f}, '{CMD_PIXEL, 8'h55}, '{CMD_PIXEL, 8'haa},
      '{CMD_PIXEL, 8'h01}, '{CMD_PIXEL, 8'hfe}, '{CMD_PIXEL, 8'h10},
      '{CMD_DRAIN, 8'h00}, '{CMD_DRAIN, 8'h00}, '{CMD_DRAIN, 8'h00}
   };

   initial begin
      int unsigned sent;
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      req_valid = 1'b0; req_data = '0;
      rsp_idle_on = 1'b0; done = 1'b0;
      foreach (win[i]) win[i] = '0;
      img_w = WIDTH_RESET; img_h = HEIGHT_RESET;
      restart_frame();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Minimum frame; extremes of register fields clamp to 3
      write_reg(REG_IMAGE_WIDTH, 32'h0);
      write_reg(REG_IMAGE_HEIGHT, 32'hffff_e002);
      foreach (directed_rows[i]) send_item(directed_rows[i].cmd, directed_rows[i].grey, 1'b0);
      send_item(CMD_DRAIN, 8'h00, 1'b0);
      wait_idle();

      // Tail cut short by a new frame
      run_frame(255, 1'b0);
      wait_idle();
      restart_frame();
      write_reg(REG_IMAGE_WIDTH, 32'd4);
      for (int i = 0; i < 12; i++) send_item(CMD_PIXEL, 8'($urandom), 1'b0);
      send_item(CMD_DRAIN, 8'h00, 1'b0);
      send_item(CMD_DRAIN, 8'h00, 1'b0);
      for (int i = 0; i < 12; i++) send_item(CMD_PIXEL, 8'($urandom), 1'b0);
      for (int i = 0; i < 5; i++) send_item(CMD_DRAIN, 8'h00, 1'b0);
      wait_idle();

      // Random frames with idling on both sides
      rsp_idle_on = 1'b1;
      sent = 0;
      while (sent < 1500) begin
         write_reg(REG_IMAGE_WIDTH, 32'($urandom_range(3, 12)));
         write_reg(REG_IMAGE_HEIGHT, 32'($urandom_range(3, 8)));
         if ($urandom_range(0, 4) == 0)
            send_item(1'($urandom), 8'($urandom), 1'b1);
         run_frame($urandom_range(0, 1) ? 255 : 7, 1'b1);
         sent += img_w * img_h + img_w + 1;
         wait_idle();
      end

      // Widest row clamps to the row store depth, then a run with no idling
      write_reg(REG_IMAGE_WIDTH, 32'hfff);
      csr_paddr <= {REG_IMAGE_WIDTH, 2'b00};
      @(posedge clock);
      if (csr_prdata !== 32'd2048)
         report_mismatch($sformatf("image_width reads %0d, want 2048", csr_prdata));
      rsp_idle_on = 1'b0;
      write_reg(REG_IMAGE_WIDTH, 32'd5);
      write_reg(REG_IMAGE_HEIGHT, 32'h1fff);
      for (int i = 0; i < 200; i++) send_item(CMD_PIXEL, 8'($urandom), 1'b0);
      wait_idle();
      write_reg(REG_IMAGE_HEIGHT, 32'd4);
      run_frame(255, 1'b0);
      wait_idle();

      done = 1'b1;
      $display("covered frames from 3x3 up to 12x8, clamped registers up to width 2048,");
      $display("stray and early drain ticks and cut-short tails; %0d results checked",
         result_count);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### files.f
design/mf3_pkg.sv
design/mf3_ram.sv
design/mf3_front.sv
design/mf3_fifo.sv
design/mf3_back.sv
design/median_filter_3x3.sv
tb/sv/median_filter_3x3_tb.sv
